// File: hdl/ardse_pkg.sv
// shared constants, widths and table generation helpers for the ard kernel core
package ardse_pkg;

    // dimension count and register map
    localparam int ARDSE_DIMS = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_SQ = 3'd6;

    // field widths
    localparam int COORD_W = 16;
    localparam int DIM_W = 3;
    localparam int WEIGHT_W = 16;
    localparam int KERNEL_W = 16;

    // reset values of the configuration registers
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd128;
    localparam logic [WEIGHT_W-1:0] AMP_RESET = 16'd256;

    // distance accumulator and exponential table
    localparam int ACC_W = 12;
    localparam logic [ACC_W-1:0] ACC_MAX = '1;
    localparam int TABLE_DEPTH = 4096;
    localparam int EXP_W = 16;

    // shared multiplier operand and product widths
    localparam int MUL_W = 32;
    localparam int PROD_W = 2 * MUL_W;

    // q1.62 fill arithmetic
    localparam int V_W = 63;
    localparam int FACC_W = 125;

    // exp(-1/256) in unsigned q2.62, alternating taylor series
    function automatic logic [63:0] exp_step_factor();
        logic [63:0] term;
        logic [63:0] factor;
        term = 64'd1 << 62;
        factor = term;
        for (int k = 1; k <= 16; k++) begin
            term = term / 64'(256 * k);
            if (k[0]) begin
                factor = factor - term;
            end else begin
                factor = factor + term;
            end
        end
        return factor;
    endfunction

    localparam logic [61:0] EXP_FACTOR = 62'(exp_step_factor());

endpackage

// File: hdl/ardse_ram.sv
// generic single-port-write ram with registered read
module ardse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/ard_squared_exponential_kernel_core.sv
// ard squared-exponential kernel core: shared multiplier, sequencer and exp table
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_stall   i_x_coord, i_y_coord, i_dim_index, i_last_dim
//  result    out        o_valid / i_stall   o_kernel_value
//  config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// an item without last_dim goes through transfer, square, weight and accumulate;
// an item with last_dim goes on through lookup, amplitude and output, plus any output stall.
// the single 32x32 multiplier serves the square, weight, amplitude and fill steps, so one
// item is in flight at a time. after reset the exp table is filled by the same multiplier,
// one entry after another; input stays stalled meanwhile, config writes are taken.
// the result register holds while i_stall is high; no new input is taken until it leaves.
module ard_squared_exponential_kernel_core
    import ardse_pkg::*;
#(
    parameter int DIMS = ARDSE_DIMS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [COORD_W-1:0]   i_x_coord,
    input  logic signed [COORD_W-1:0]   i_y_coord,
    input  logic [DIM_W-1:0]            i_dim_index,
    input  logic                        i_last_dim,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [KERNEL_W-1:0]         o_kernel_value,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int DIM_IW = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam logic [DIM_W-1:0] DIM_CODE = DIM_W'(DIMS);
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(TABLE_DEPTH - 1);

    typedef enum logic [3:0] {
        S_FILL_WR,
        S_FILL_M1,
        S_FILL_M2,
        S_FILL_M3,
        S_FILL_ADD,
        S_FILL_NEXT,
        S_IDLE,
        S_SQ,
        S_WT,
        S_ACC,
        S_LOOK,
        S_AMP,
        S_OUT
    } t_state;

    t_state                 r_state, n_state;
    logic [WEIGHT_W-1:0]    r_weight [DIMS];
    logic [WEIGHT_W-1:0]    r_amp;
    logic [ACC_W-1:0]       r_acc;
    logic [COORD_W-1:0]     r_absd;
    logic [DIM_W-1:0]       r_dim;
    logic                   r_last;
    logic [PROD_W-1:0]      r_prod;
    logic [V_W-1:0]         r_v;
    logic [FACC_W-1:0]      r_facc;
    logic [ADDR_W-1:0]      r_fidx;

    logic                   in_xfer;
    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]       diff_abs;
    logic [MUL_W-1:0]       mul_a, mul_b;
    logic                   mul_en;
    logic [FACC_W-1:0]      addend;
    logic [WEIGHT_W-1:0]    w_sel;
    logic [ACC_W-1:0]       headroom;
    logic                   acc_sat;
    logic [ACC_W-1:0]       acc_new;
    logic [EXP_W+1:0]       round_sum;
    logic                   ram_we;
    logic [EXP_W-1:0]       ram_wdata;
    logic [EXP_W-1:0]       ram_rdata;

    // handshakes
    assign o_stall = (r_state != S_IDLE);
    assign in_xfer = i_valid && !o_stall;
    assign o_valid = (r_state == S_OUT);
    assign o_kernel_value = r_prod[30:15];

    // coordinate difference magnitude
    always_comb begin
        diff = (COORD_W+1)'(i_x_coord) - (COORD_W+1)'(i_y_coord);
        diff_abs = diff[COORD_W] ? (COORD_W+1)'(-diff) : diff;
    end

    // weight of the held dimension, zero when out of range
    assign w_sel = (r_dim < DIM_CODE) ? r_weight[r_dim[DIM_IW-1:0]] : '0;

    // saturating accumulate of the weighted term
    always_comb begin
        headroom = ACC_MAX - r_acc;
        acc_sat = (r_prod[39:8] >= 32'(headroom));
        acc_new = acc_sat ? ACC_MAX : r_acc + r_prod[8+ACC_W-1:8];
    end

    // table entry from q1.62 value, rounded half up to 15 fraction bits
    assign round_sum = (EXP_W+2)'(r_v[V_W-1:46]) + (EXP_W+2)'(1);
    assign ram_wdata = round_sum[EXP_W:1];
    assign ram_we = (r_state == S_FILL_WR);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        mul_en = 1'b0;
        unique case (r_state)
            S_FILL_WR: begin
                mul_a = r_v[31:0];
                mul_b = EXP_FACTOR[31:0];
                mul_en = 1'b1;
            end
            S_FILL_M1: begin
                mul_a = r_v[31:0];
                mul_b = {2'b00, EXP_FACTOR[61:32]};
                mul_en = 1'b1;
            end
            S_FILL_M2: begin
                mul_a = {1'b0, r_v[62:32]};
                mul_b = EXP_FACTOR[31:0];
                mul_en = 1'b1;
            end
            S_FILL_M3: begin
                mul_a = {1'b0, r_v[62:32]};
                mul_b = {2'b00, EXP_FACTOR[61:32]};
                mul_en = 1'b1;
            end
            S_SQ: begin
                mul_a = MUL_W'(r_absd);
                mul_b = MUL_W'(r_absd);
                mul_en = 1'b1;
            end
            S_WT: begin
                mul_a = MUL_W'(r_prod[31:8]);
                mul_b = MUL_W'(w_sel);
                mul_en = 1'b1;
            end
            S_AMP: begin
                mul_a = MUL_W'(r_amp);
                mul_b = MUL_W'(ram_rdata);
                mul_en = 1'b1;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // partial product alignment for the fill accumulator
    always_comb begin
        unique case (r_state)
            S_FILL_M1:  addend = FACC_W'(r_prod);
            S_FILL_M2:  addend = FACC_W'({r_prod, 32'b0});
            S_FILL_M3:  addend = FACC_W'({r_prod, 32'b0});
            S_FILL_ADD: addend = FACC_W'({r_prod, 64'b0});
            default:    addend = '0;
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_FILL_WR:   n_state = (r_fidx == LAST_ENTRY) ? S_IDLE : S_FILL_M1;
            S_FILL_M1:   n_state = S_FILL_M2;
            S_FILL_M2:   n_state = S_FILL_M3;
            S_FILL_M3:   n_state = S_FILL_ADD;
            S_FILL_ADD:  n_state = S_FILL_NEXT;
            S_FILL_NEXT: n_state = S_FILL_WR;
            S_IDLE:      n_state = in_xfer ? S_SQ : S_IDLE;
            S_SQ:        n_state = S_WT;
            S_WT:        n_state = S_ACC;
            S_ACC:       n_state = r_last ? S_LOOK : S_IDLE;
            S_LOOK:      n_state = S_AMP;
            S_AMP:       n_state = S_OUT;
            S_OUT:       n_state = i_stall ? S_OUT : S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // state, datapath and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL_WR;
            r_acc <= '0;
            r_fidx <= '0;
            r_v <= V_W'(1) << 62;
            r_amp <= AMP_RESET;
            for (int i = 0; i < DIMS; i++) begin
                r_weight[i] <= WEIGHT_RESET;
            end
        end else begin
            r_state <= n_state;

            if (mul_en) begin
                r_prod <= mul_a * mul_b;
            end

            case (r_state)
                S_FILL_WR: begin
                    r_facc <= FACC_W'(1) << 61;
                end
                S_FILL_M1, S_FILL_M2, S_FILL_M3, S_FILL_ADD: begin
                    r_facc <= r_facc + addend;
                end
                S_FILL_NEXT: begin
                    r_v <= r_facc[FACC_W-1:62];
                    r_fidx <= r_fidx + ADDR_W'(1);
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_absd <= diff_abs[COORD_W-1:0];
                        r_dim <= i_dim_index;
                        r_last <= i_last_dim;
                    end
                end
                S_ACC: begin
                    r_acc <= acc_new;
                end
                S_LOOK: begin
                    r_acc <= '0;
                end
                default: begin
                end
            endcase

            // configuration writes
            if (i_cfg_we) begin
                if (i_cfg_index < DIM_CODE) begin
                    r_weight[i_cfg_index[DIM_IW-1:0]] <= i_cfg_data;
                end else if (i_cfg_index == CFG_AMP_SQ) begin
                    r_amp <= i_cfg_data;
                end
            end
        end
    end

    // exponential table, read at the accumulated distance
    ardse_ram #(
        .WIDTH (EXP_W),
        .DEPTH (TABLE_DEPTH)
    ) u_exp_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fidx),
        .i_wdata (ram_wdata),
        .i_raddr (r_acc),
        .o_rdata (ram_rdata)
    );

endmodule

// File: verif/ard_squared_exponential_kernel_core_tb.sv
// testbench for the ard squared-exponential kernel core with a self-checking predictor
`timescale 1ns / 100ps

module ard_squared_exponential_kernel_core_tb;
    import ardse_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
    localparam logic [WEIGHT_W-1:0] REG_MIN = 16'h0000;
    localparam logic [WEIGHT_W-1:0] REG_MAX = 16'hffff;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7fff;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic signed [COORD_W-1:0]  i_x_coord = '0;
    logic signed [COORD_W-1:0]  i_y_coord = '0;
    logic [DIM_W-1:0]           i_dim_index = '0;
    logic                       i_last_dim = 1'b0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [KERNEL_W-1:0]        o_kernel_value;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;

    // predictor state: register copies, distance sum and exp rom
    logic [WEIGHT_W-1:0]        weight_q [ARDSE_DIMS];
    logic [WEIGHT_W-1:0]        amp_q;
    longint unsigned            model_distance;
    logic [EXP_W-1:0]           exp_rom [TABLE_DEPTH];
    logic [KERNEL_W-1:0]        pending_kernels [$];

    int                         error_count = 0;
    int                         cycle_count = 0;
    int                         stall_left = 0;
    bit                         idle_on = 1'b1;

    ard_squared_exponential_kernel_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_x_coord      (i_x_coord),
        .i_y_coord      (i_y_coord),
        .i_dim_index    (i_dim_index),
        .i_last_dim     (i_last_dim),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kernel_value (o_kernel_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // exp(-i/256) in q1.15: q2.62 step factor from a taylor series, powers rounded half up
    function automatic void build_exp_rom();
        logic [63:0]  tay;
        logic [63:0]  step;
        logic [63:0]  pow;
        logic [127:0] prod;
        tay = 64'd1 << 62;
        step = tay;
        pow = tay;
        for (int k = 1; k <= 16; k++) begin
            tay = tay / (64'd256 * k);
            if (k % 2 == 1) begin
                step = step - tay;
            end else begin
                step = step + tay;
            end
        end
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            exp_rom[i] = EXP_W'((pow + (64'd1 << 46)) >> 47);
            prod = 128'(pow) * 128'(step);
            pow = 64'((prod + (128'd1 << 61)) >> 62);
        end
    endfunction

    // add one weighted squared distance term, queue a kernel value on the last dimension
    function automatic void accumulate_pair(input logic signed [COORD_W-1:0] x,
                                            input logic signed [COORD_W-1:0] y,
                                            input logic [DIM_W-1:0] dim,
                                            input logic last);
        longint          diff;
        longint unsigned sq;
        longint unsigned w;
        longint unsigned term;
        diff = longint'(x) - longint'(y);
        sq = $unsigned(diff * diff) >> 8;
        w = (dim < ARDSE_DIMS) ? 64'(weight_q[dim]) : 64'd0;
        term = (sq * w) >> 8;
        if (term >= 64'(ACC_MAX) - model_distance) begin
            model_distance = 64'(ACC_MAX);
        end else begin
            model_distance = model_distance + term;
        end
        if (last) begin
            pending_kernels.push_back(
                KERNEL_W'((32'(amp_q) * 32'(exp_rom[model_distance])) >> 15));
            model_distance = 0;
        end
    endfunction

    // mostly near-origin coordinates, a quarter over the full signed range
    function automatic logic signed [COORD_W-1:0] rand_coord();
        if ($urandom_range(0, 3) == 0) begin
            return COORD_W'($urandom_range(0, 65535));
        end
        return COORD_W'(int'($urandom_range(0, 1023)) - 512);
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_near(input logic signed [COORD_W-1:0] x);
        return COORD_W'(int'(x) + int'($urandom_range(0, 255)) - 128);
    endfunction

    // one register write, with write enable dropped again before the task returns
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx < ARDSE_DIMS) begin
            weight_q[idx] = data;
        end else if (idx == CFG_AMP_SQ) begin
            amp_q = data;
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_all_weights(input logic [WEIGHT_W-1:0] w);
        for (int d = 0; d < ARDSE_DIMS; d++) begin
            write_reg(CFG_IDX_W'(d), w);
        end
    endtask

    // one coordinate pair transfer, with an optional idle burst in front
    task automatic send_pair(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic [DIM_W-1:0] dim,
                             input logic last);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_x_coord <= x;
        i_y_coord <= y;
        i_dim_index <= dim;
        i_last_dim <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        accumulate_pair(x, y, dim, last);
    endtask

    // drop valid, wait for every kernel value, then let the core go quiet
    task automatic finish_phase();
        i_valid <= 1'b0;
        while (pending_kernels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // well-formed point pairs with random content, plus noise and broken pairs
    task automatic run_point_pairs(input int count);
        int sent;
        int kind;
        int ndims;
        logic signed [COORD_W-1:0] x;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                send_pair(rand_coord(), rand_coord(), DIM_W'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)));
                sent++;
            end else begin
                ndims = $urandom_range(1, ARDSE_DIMS);
                for (int k = 0; k < ndims; k++) begin
                    x = rand_coord();
                    send_pair(x, ($urandom_range(0, 1) == 1) ? rand_near(x) : rand_coord(),
                              (kind == 2) ? DIM_W'($urandom_range(0, 7)) : DIM_W'(k),
                              (k == ndims - 1) && (kind != 1));
                    sent++;
                end
            end
        end
        finish_phase();
    endtask

    // weights from one of three spreads, amplitude over its full range
    task automatic program_registers(input int spread);
        for (int d = 0; d < ARDSE_DIMS; d++) begin
            case (spread)
                0: write_reg(CFG_IDX_W'(d), WEIGHT_W'($urandom_range(0, 1024)));
                1: write_reg(CFG_IDX_W'(d), WEIGHT_W'($urandom_range(0, 65535)));
                default: begin
                    case ($urandom_range(0, 2))
                        0: write_reg(CFG_IDX_W'(d), REG_MIN);
                        1: write_reg(CFG_IDX_W'(d), REG_MAX);
                        default: write_reg(CFG_IDX_W'(d), WEIGHT_W'($urandom_range(1, 300)));
                    endcase
                end
            endcase
        end
        write_reg(CFG_AMP_SQ, CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom_range(0, 65535)));
    endtask

    // reset register values: zero distance, saturation, unused dimensions, multi-dim pairs
    task automatic test_reset_defaults();
        send_pair(16'sd0, 16'sd0, 3'd0, 1'b1);
        send_pair(16'sd256, 16'sd0, 3'd0, 1'b1);
        send_pair(COORD_MAX, COORD_MIN, 3'd0, 1'b1);
        send_pair(COORD_MIN, COORD_MAX, 3'd5, 1'b1);
        send_pair(COORD_MIN, COORD_MIN, 3'd3, 1'b1);
        send_pair(16'sd100, -16'sd100, 3'd6, 1'b1);
        send_pair(COORD_MAX, COORD_MIN, 3'd7, 1'b1);
        for (int d = 0; d < ARDSE_DIMS; d++) begin
            send_pair(COORD_W'(128 * d), -16'sd64, DIM_W'(d), d == ARDSE_DIMS - 1);
        end
        send_pair(16'sd300, 16'sd0, 3'd2, 1'b0);
        send_pair(COORD_MAX, COORD_MIN, 3'd7, 1'b0);
        send_pair(-16'sd200, 16'sd100, 3'd1, 1'b1);
        finish_phase();
    endtask

    // register extremes and the unmapped register index
    task automatic test_register_extremes();
        set_all_weights(REG_MIN);
        write_reg(CFG_AMP_SQ, REG_MAX);
        send_pair(COORD_MAX, COORD_MIN, 3'd0, 1'b1);
        finish_phase();
        set_all_weights(REG_MAX);
        write_reg(CFG_AMP_SQ, REG_MIN);
        send_pair(16'sd16, 16'sd0, 3'd4, 1'b1);
        finish_phase();
        write_reg(CFG_AMP_SQ, REG_MAX);
        send_pair(16'sd1, 16'sd0, 3'd1, 1'b1);
        send_pair(16'sd16, 16'sd0, 3'd2, 1'b1);
        finish_phase();
        write_reg(CFG_UNMAPPED, REG_MIN);
        send_pair(16'sd40, 16'sd0, 3'd5, 1'b1);
        finish_phase();
    endtask

    task automatic test_random_pairs();
        for (int spread = 0; spread < 3; spread++) begin
            program_registers(spread);
            run_point_pairs(230);
        end
    endtask

    // back to back transfers with no idling on either side
    task automatic test_steady_stream();
        idle_on = 1'b0;
        program_registers(0);
        run_point_pairs(300);
    endtask

    // stall bursts on the result side
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 19);
        end
        i_stall <= (stall_left > 0);
    end

    // compare each result transfer with the oldest expected kernel value
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_kernels.size() == 0) begin
                $display("%0t: kernel_value %0d with none expected", $time, o_kernel_value);
                error_count++;
            end else begin
                if (o_kernel_value !== pending_kernels[0]) begin
                    $display("%0t: kernel_value mismatch, expected %0d, actual %0d",
                             $time, pending_kernels[0], o_kernel_value);
                    error_count++;
                end
                void'(pending_kernels.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ard_squared_exponential_kernel_core verification failed");
            $finish;
        end
    end

    initial begin
        for (int d = 0; d < ARDSE_DIMS; d++) begin
            weight_q[d] = WEIGHT_RESET;
        end
        amp_q = AMP_RESET;
        model_distance = 0;
        build_exp_rom();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_register_extremes();
        test_random_pairs();
        test_steady_stream();
        if (error_count == 0) begin
            $display("ard_squared_exponential_kernel_core verification clean");
        end else begin
            $display("ard_squared_exponential_kernel_core verification failed");
        end
        $finish;
    end

endmodule
